// ===== src/tbvc_pkg.sv =====
// Package for the triangle tile binning block with vertex index compaction.
// Holds sequencer states, memory control struct, register codes, constants and a times3 helper.
// No dependencies.
`timescale 1ns / 1ps

package tbvc_pkg;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_CLR_OUT,
        S_IDLE,
        S_A,
        S_B,
        S_C
    } t_state;

    typedef struct packed {
        logic rd_en;
        logic wr_used;
        logic used_val;
        logic wr_index;
    } t_mem_ctl;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TILE_U_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TILE_U_HIGH = 2'd1;

    localparam logic signed [31:0] TILE_U_LOW_RESET  = 32'sh0000_0000;
    localparam logic signed [31:0] TILE_U_HIGH_RESET = 32'sh7FFF_FFFF;

    localparam logic [23:0] FACE_MAX   = 24'hFF_FFFF;
    localparam logic [16:0] VERTEX_MAX = 17'h1_FFFF;

    function automatic logic signed [33:0] times3(input logic signed [31:0] v);
        logic signed [33:0] w;
        w = $signed({{2{v[31]}}, v});
        return (w <<< 1) + w;
    endfunction

endpackage

// ===== src/triangle_tile_bin_vertex_compact.sv =====
// Triangle tile binning with per-tile vertex index compaction, top level.
// Uses tbvc_pkg, tbvc_map_mem, tbvc_range_check, tbvc_ctrl.
//
// Input channel: i_valid / o_in_stall carries one item, either a face (three
// vertex indices and u coordinates) or a clear request. Output channel:
// o_out_valid / i_out_stall returns one result item per input item.
// Config: i_cfg_we / i_cfg_index / i_cfg_data write tile_u_low (0) and
// tile_u_high (1); other indices are ignored. Write only while idle.
// A face is accepted, then runs three lookups, one per vertex, each through
// the registered read port of the map memory. The result is registered and
// appears the cycle after the third lookup. A clear request walks the used
// map one entry a cycle, then returns its result before the next item is
// taken. After reset the same pass runs with o_in_stall high and no result.
// While the receiver stalls, the result holds; a following item is still
// accepted and runs up to its last lookup, then waits for the output
// register to free.
`timescale 1ns / 1ps

module triangle_tile_bin_vertex_compact #(
    parameter int VERTEX_COUNT = 65536
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tbvc_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [31:0]                       i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_in_stall,
    input  logic                              i_req_type,
    input  logic [15:0]                       i_index_a,
    input  logic [15:0]                       i_index_b,
    input  logic [15:0]                       i_index_c,
    input  logic signed [31:0]                i_coord_a,
    input  logic signed [31:0]                i_coord_b,
    input  logic signed [31:0]                i_coord_c,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_in_tile,
    output logic [15:0]                       o_new_a,
    output logic [15:0]                       o_new_b,
    output logic [15:0]                       o_new_c,
    output logic [23:0]                       o_faces_in_tile,
    output logic [16:0]                       o_vertices_in_tile
);

    localparam int DEPTH = (VERTEX_COUNT < 65536) ? VERTEX_COUNT : 65536;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    tbvc_pkg::t_mem_ctl mem_ctl;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic [15:0]        wr_index, rd_index;
    logic               rd_used;
    logic               load, in_range;

    tbvc_range_check u_range (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_load      (load),
        .i_coord_a   (i_coord_a),
        .i_coord_b   (i_coord_b),
        .i_coord_c   (i_coord_c),
        .o_in_range  (in_range)
    );

    tbvc_map_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk      (i_clk),
        .i_ctl      (mem_ctl),
        .i_rd_addr  (rd_addr),
        .i_wr_addr  (wr_addr),
        .i_wr_index (wr_index),
        .o_rd_used  (rd_used),
        .o_rd_index (rd_index)
    );

    tbvc_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_in_stall         (o_in_stall),
        .i_req_type         (i_req_type),
        .i_index_a          (i_index_a),
        .i_index_b          (i_index_b),
        .i_index_c          (i_index_c),
        .o_load             (load),
        .i_in_range         (in_range),
        .o_mem_ctl          (mem_ctl),
        .o_rd_addr          (rd_addr),
        .o_wr_addr          (wr_addr),
        .o_wr_index         (wr_index),
        .i_rd_used          (rd_used),
        .i_rd_index         (rd_index),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_in_tile          (o_in_tile),
        .o_new_a            (o_new_a),
        .o_new_b            (o_new_b),
        .o_new_c            (o_new_c),
        .o_faces_in_tile    (o_faces_in_tile),
        .o_vertices_in_tile (o_vertices_in_tile)
    );

endmodule

// ===== src/tbvc_map_mem.sv =====
// Vertex map memories: used-bit map and compacted index store.
// One write port and one registered read port each, sharing addresses.
// Uses tbvc_pkg.
`timescale 1ns / 1ps

module tbvc_map_mem #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic                i_clk,
    input  tbvc_pkg::t_mem_ctl  i_ctl,
    input  logic [AW-1:0]       i_rd_addr,
    input  logic [AW-1:0]       i_wr_addr,
    input  logic [15:0]         i_wr_index,
    output logic                o_rd_used,
    output logic [15:0]         o_rd_index
);

    logic        r_used_mem  [DEPTH];
    logic [15:0] r_index_mem [DEPTH];
    logic        r_rd_used;
    logic [15:0] r_rd_index;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_used) begin
            r_used_mem[i_wr_addr] <= i_ctl.used_val;
        end
        if (i_ctl.rd_en) begin
            r_rd_used <= r_used_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_index) begin
            r_index_mem[i_wr_addr] <= i_wr_index;
        end
        if (i_ctl.rd_en) begin
            r_rd_index <= r_index_mem[i_rd_addr];
        end
    end

    assign o_rd_used  = r_rd_used;
    assign o_rd_index = r_rd_index;

endmodule

// ===== src/tbvc_range_check.sv =====
// Tile range check: holds 3*low and 3*high bounds and the face u coordinates,
// compares the u sum against the bounds. Uses tbvc_pkg.
`timescale 1ns / 1ps

module tbvc_range_check (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tbvc_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [31:0]                        i_cfg_data,
    input  logic                               i_load,
    input  logic signed [31:0]                 i_coord_a,
    input  logic signed [31:0]                 i_coord_b,
    input  logic signed [31:0]                 i_coord_c,
    output logic                               o_in_range
);

    logic signed [33:0] r_lo3, r_hi3;
    logic signed [31:0] r_ca, r_cb, r_cc;
    logic signed [33:0] sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo3 <= tbvc_pkg::times3(tbvc_pkg::TILE_U_LOW_RESET);
            r_hi3 <= tbvc_pkg::times3(tbvc_pkg::TILE_U_HIGH_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tbvc_pkg::CFG_TILE_U_LOW:  r_lo3 <= tbvc_pkg::times3($signed(i_cfg_data));
                tbvc_pkg::CFG_TILE_U_HIGH: r_hi3 <= tbvc_pkg::times3($signed(i_cfg_data));
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ca <= i_coord_a;
            r_cb <= i_coord_b;
            r_cc <= i_coord_c;
        end
    end

    assign sum = $signed({{2{r_ca[31]}}, r_ca}) + $signed({{2{r_cb[31]}}, r_cb})
               + $signed({{2{r_cc[31]}}, r_cc});

    assign o_in_range = (sum >= r_lo3) && (sum < r_hi3);

endmodule

// ===== src/tbvc_ctrl.sv =====
// Sequencer: accepts items, runs three read-modify-write lookups in the map,
// forwards repeated indices, keeps counts, clears the map, drives the result.
// Uses tbvc_pkg.
`timescale 1ns / 1ps

module tbvc_ctrl #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_in_stall,
    input  logic                i_req_type,
    input  logic [15:0]         i_index_a,
    input  logic [15:0]         i_index_b,
    input  logic [15:0]         i_index_c,
    output logic                o_load,
    input  logic                i_in_range,
    output tbvc_pkg::t_mem_ctl  o_mem_ctl,
    output logic [AW-1:0]       o_rd_addr,
    output logic [AW-1:0]       o_wr_addr,
    output logic [15:0]         o_wr_index,
    input  logic                i_rd_used,
    input  logic [15:0]         i_rd_index,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_in_tile,
    output logic [15:0]         o_new_a,
    output logic [15:0]         o_new_b,
    output logic [15:0]         o_new_c,
    output logic [23:0]         o_faces_in_tile,
    output logic [16:0]         o_vertices_in_tile
);

    localparam logic [16:0]   DEPTH_L = 17'(DEPTH);
    localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);

    tbvc_pkg::t_state r_state, n_state;

    logic [15:0]   r_ia, r_ib, r_ic, n_ia, n_ib, n_ic;
    logic [15:0]   r_na, r_nb, n_na, n_nb, nc;
    logic          r_pass, n_pass;
    logic [16:0]   r_vcount, n_vcount, vinc;
    logic [23:0]   r_fcount, n_fcount;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic          r_clr_report, n_clr_report;

    logic          r_out_valid, n_out_valid;
    logic          r_o_in_tile, n_o_in_tile;
    logic [15:0]   r_o_new_a, r_o_new_b, r_o_new_c, n_o_new_a, n_o_new_b, n_o_new_c;
    logic [23:0]   r_o_faces, n_o_faces;
    logic [16:0]   r_o_verts, n_o_verts;

    logic          accept, out_free, face_ok;
    logic [15:0]   lookup;

    function automatic logic idx_ok(input logic [15:0] idx);
        return {1'b0, idx} < DEPTH_L;
    endfunction

    assign accept   = i_valid && (r_state == tbvc_pkg::S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign face_ok  = i_in_range && idx_ok(r_ia) && idx_ok(r_ib) && idx_ok(r_ic);
    assign lookup   = i_rd_used ? i_rd_index : r_vcount[15:0];
    assign vinc     = (r_vcount < tbvc_pkg::VERTEX_MAX) ? r_vcount + 17'd1 : r_vcount;

    always_comb begin
        n_state = r_state;
        case (r_state)
            tbvc_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = i_req_type ? tbvc_pkg::S_CLEAR : tbvc_pkg::S_A;
                end
            end
            tbvc_pkg::S_CLEAR: begin
                if (r_clr_addr == LAST) begin
                    n_state = r_clr_report ? tbvc_pkg::S_CLR_OUT : tbvc_pkg::S_IDLE;
                end
            end
            tbvc_pkg::S_CLR_OUT: begin
                if (out_free) n_state = tbvc_pkg::S_IDLE;
            end
            tbvc_pkg::S_A: n_state = tbvc_pkg::S_B;
            tbvc_pkg::S_B: n_state = tbvc_pkg::S_C;
            tbvc_pkg::S_C: begin
                if (out_free) n_state = tbvc_pkg::S_IDLE;
            end
            default: n_state = tbvc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_mem_ctl    = '0;
        o_rd_addr    = i_index_a[AW-1:0];
        o_wr_addr    = r_ia[AW-1:0];
        o_wr_index   = r_vcount[15:0];
        n_ia         = r_ia;
        n_ib         = r_ib;
        n_ic         = r_ic;
        n_na         = r_na;
        n_nb         = r_nb;
        nc           = 16'd0;
        n_pass       = r_pass;
        n_vcount     = r_vcount;
        n_fcount     = r_fcount;
        n_clr_addr   = r_clr_addr;
        n_clr_report = r_clr_report;
        n_out_valid  = r_out_valid && i_out_stall;
        n_o_in_tile  = r_o_in_tile;
        n_o_new_a    = r_o_new_a;
        n_o_new_b    = r_o_new_b;
        n_o_new_c    = r_o_new_c;
        n_o_faces    = r_o_faces;
        n_o_verts    = r_o_verts;
        case (r_state)
            tbvc_pkg::S_IDLE: begin
                if (accept) begin
                    n_ia = i_index_a;
                    n_ib = i_index_b;
                    n_ic = i_index_c;
                    if (i_req_type) begin
                        n_vcount     = '0;
                        n_fcount     = '0;
                        n_clr_addr   = '0;
                        n_clr_report = 1'b1;
                    end else begin
                        o_mem_ctl.rd_en = 1'b1;
                    end
                end
            end
            tbvc_pkg::S_CLEAR: begin
                o_mem_ctl.wr_used  = 1'b1;
                o_mem_ctl.used_val = 1'b0;
                o_wr_addr          = r_clr_addr;
                n_clr_addr         = r_clr_addr + 1'b1;
            end
            tbvc_pkg::S_CLR_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_in_tile = 1'b0;
                    n_o_new_a   = '0;
                    n_o_new_b   = '0;
                    n_o_new_c   = '0;
                    n_o_faces   = r_fcount;
                    n_o_verts   = r_vcount;
                end
            end
            tbvc_pkg::S_A: begin
                o_mem_ctl.rd_en = 1'b1;
                o_rd_addr       = r_ib[AW-1:0];
                o_wr_addr       = r_ia[AW-1:0];
                n_pass          = face_ok;
                n_na            = '0;
                if (face_ok) begin
                    n_na = lookup;
                    if (!i_rd_used) begin
                        o_mem_ctl.wr_used  = 1'b1;
                        o_mem_ctl.used_val = 1'b1;
                        o_mem_ctl.wr_index = 1'b1;
                        n_vcount           = vinc;
                    end
                end
            end
            tbvc_pkg::S_B: begin
                o_mem_ctl.rd_en = 1'b1;
                o_rd_addr       = r_ic[AW-1:0];
                o_wr_addr       = r_ib[AW-1:0];
                n_nb            = '0;
                if (r_pass) begin
                    if (r_ib == r_ia) begin
                        n_nb = r_na;
                    end else begin
                        n_nb = lookup;
                        if (!i_rd_used) begin
                            o_mem_ctl.wr_used  = 1'b1;
                            o_mem_ctl.used_val = 1'b1;
                            o_mem_ctl.wr_index = 1'b1;
                            n_vcount           = vinc;
                        end
                    end
                end
            end
            tbvc_pkg::S_C: begin
                o_wr_addr = r_ic[AW-1:0];
                if (out_free) begin
                    if (r_pass) begin
                        if (r_ic == r_ib) begin
                            nc = r_nb;
                        end else if (r_ic == r_ia) begin
                            nc = r_na;
                        end else begin
                            nc = lookup;
                            if (!i_rd_used) begin
                                o_mem_ctl.wr_used  = 1'b1;
                                o_mem_ctl.used_val = 1'b1;
                                o_mem_ctl.wr_index = 1'b1;
                                n_vcount           = vinc;
                            end
                        end
                        if (r_fcount != tbvc_pkg::FACE_MAX) begin
                            n_fcount = r_fcount + 24'd1;
                        end
                    end
                    n_out_valid = 1'b1;
                    n_o_in_tile = r_pass;
                    n_o_new_a   = r_na;
                    n_o_new_b   = r_nb;
                    n_o_new_c   = nc;
                    n_o_faces   = n_fcount;
                    n_o_verts   = n_vcount;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tbvc_pkg::S_CLEAR;
            r_pass       <= 1'b0;
            r_vcount     <= '0;
            r_fcount     <= '0;
            r_clr_addr   <= '0;
            r_clr_report <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pass       <= n_pass;
            r_vcount     <= n_vcount;
            r_fcount     <= n_fcount;
            r_clr_addr   <= n_clr_addr;
            r_clr_report <= n_clr_report;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ia        <= n_ia;
        r_ib        <= n_ib;
        r_ic        <= n_ic;
        r_na        <= n_na;
        r_nb        <= n_nb;
        r_o_in_tile <= n_o_in_tile;
        r_o_new_a   <= n_o_new_a;
        r_o_new_b   <= n_o_new_b;
        r_o_new_c   <= n_o_new_c;
        r_o_faces   <= n_o_faces;
        r_o_verts   <= n_o_verts;
    end

    assign o_in_stall         = (r_state != tbvc_pkg::S_IDLE);
    assign o_load             = accept;
    assign o_out_valid        = r_out_valid;
    assign o_in_tile          = r_o_in_tile;
    assign o_new_a            = r_o_new_a;
    assign o_new_b            = r_o_new_b;
    assign o_new_c            = r_o_new_c;
    assign o_faces_in_tile    = r_o_faces;
    assign o_vertices_in_tile = r_o_verts;

endmodule

// ===== tb/triangle_tile_bin_vertex_compact_test.sv =====
// Testbench for triangle_tile_bin_vertex_compact: directed table, then random phases
// under several tile ranges, checked against typed table rows or an in-bench model.
// Depends on tbvc_pkg and the triangle_tile_bin_vertex_compact RTL.
`timescale 1ns / 1ps

module triangle_tile_bin_vertex_compact_test;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 10;
    localparam int SETTLE_CYCLES   = 8;
    localparam int LONG_HOLD       = 300;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 68;
    localparam int QUIET_PHASE     = 6;
    localparam int POOL_SIZE       = 32;
    localparam int DIR_ROWS        = 13;
    localparam int unsigned CYCLE_LIMIT = 3_000_000;

    localparam logic [tbvc_pkg::CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [tbvc_pkg::CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef enum logic {
        REQ_FACE  = 1'b0,
        REQ_CLEAR = 1'b1
    } t_req_kind;

    typedef struct packed {
        t_req_kind   kind;
        logic [15:0] ia;
        logic [15:0] ib;
        logic [15:0] ic;
        logic [31:0] ua;
        logic [31:0] ub;
        logic [31:0] uc;
    } t_face_req;

    typedef struct packed {
        logic        in_tile;
        logic [15:0] na;
        logic [15:0] nb;
        logic [15:0] nc;
        logic [23:0] faces;
        logic [16:0] verts;
    } t_bin_result;

    typedef struct packed {
        t_face_req   req;
        logic        typed;
        t_bin_result want;
    } t_dir_row;

    localparam t_bin_result UNTYPED = '0;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_we = 1'b0;
    logic [tbvc_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [31:0]                      i_cfg_data = '0;
    logic                             i_valid = 1'b0;
    logic                             o_in_stall;
    logic                             i_req_type = 1'b0;
    logic [15:0]                      i_index_a = '0;
    logic [15:0]                      i_index_b = '0;
    logic [15:0]                      i_index_c = '0;
    logic signed [31:0]               i_coord_a = '0;
    logic signed [31:0]               i_coord_b = '0;
    logic signed [31:0]               i_coord_c = '0;
    logic                             o_out_valid;
    logic                             i_out_stall = 1'b0;
    logic                             o_in_tile;
    logic [15:0]                      o_new_a;
    logic [15:0]                      o_new_b;
    logic [15:0]                      o_new_c;
    logic [23:0]                      o_faces_in_tile;
    logic [16:0]                      o_vertices_in_tile;

    // binning model state
    logic [31:0] tile_lo = tbvc_pkg::TILE_U_LOW_RESET;
    logic [31:0] tile_hi = tbvc_pkg::TILE_U_HIGH_RESET;
    bit          vtx_seen [65536];
    logic [15:0] vtx_new [65536];
    logic [16:0] vtx_total = '0;
    logic [23:0] face_total = '0;

    t_bin_result pending_bins[$];
    logic [15:0] vtx_pool [POOL_SIZE];
    t_dir_row    directed_rows [DIR_ROWS];
    int          errors = 0;
    int          clears_left = 4;
    bit          send_idle = 1'b1;
    logic        recv_idle = 1'b1;
    logic        hold_arm = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_left = 0;
    int unsigned cycle_count = 0;

    triangle_tile_bin_vertex_compact dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_in_stall         (o_in_stall),
        .i_req_type         (i_req_type),
        .i_index_a          (i_index_a),
        .i_index_b          (i_index_b),
        .i_index_c          (i_index_c),
        .i_coord_a          (i_coord_a),
        .i_coord_b          (i_coord_b),
        .i_coord_c          (i_coord_c),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_in_tile          (o_in_tile),
        .o_new_a            (o_new_a),
        .o_new_b            (o_new_b),
        .o_new_c            (o_new_c),
        .o_faces_in_tile    (o_faces_in_tile),
        .o_vertices_in_tile (o_vertices_in_tile)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic logic [15:0] compact_index(input logic [15:0] v);
        if (!vtx_seen[v]) begin
            vtx_seen[v] = 1'b1;
            vtx_new[v] = vtx_total[15:0];
            if (vtx_total < tbvc_pkg::VERTEX_MAX) vtx_total = vtx_total + 17'd1;
        end
        return vtx_new[v];
    endfunction

    function automatic t_bin_result bin_face(input t_face_req r);
        t_bin_result res;
        longint      sum;
        longint      lo3;
        longint      hi3;
        res = '0;
        if (r.kind == REQ_CLEAR) begin
            foreach (vtx_seen[k]) vtx_seen[k] = 1'b0;
            vtx_total = '0;
            face_total = '0;
        end else begin
            sum = longint'($signed(r.ua)) + longint'($signed(r.ub)) + longint'($signed(r.uc));
            lo3 = 3 * longint'($signed(tile_lo));
            hi3 = 3 * longint'($signed(tile_hi));
            if (sum >= lo3 && sum < hi3) begin
                res.in_tile = 1'b1;
                res.na = compact_index(r.ia);
                res.nb = compact_index(r.ib);
                res.nc = compact_index(r.ic);
                if (face_total < tbvc_pkg::FACE_MAX) face_total = face_total + 24'd1;
            end
        end
        res.faces = face_total;
        res.verts = vtx_total;
        return res;
    endfunction

    function automatic logic [31:0] coord_between(input longint lo_s, input longint hi_s);
        logic [63:0] draw;
        logic [63:0] pick;
        draw = {$urandom, $urandom};
        pick = lo_s + longint'(draw % $unsigned(hi_s - lo_s));
        return pick[31:0];
    endfunction

    function automatic logic [15:0] pick_index();
        if ($urandom_range(0, 3) != 0) return vtx_pool[$urandom_range(0, POOL_SIZE - 1)];
        return 16'($urandom);
    endfunction

    // mostly faces spread over the tile or on its edges, some noise and rare clears
    function automatic t_face_req random_request();
        t_face_req   r;
        longint      lo_s;
        longint      hi_s;
        int          mode;
        logic [31:0] base;
        lo_s = longint'($signed(tile_lo));
        hi_s = longint'($signed(tile_hi));
        r.kind = REQ_FACE;
        r.ia = pick_index();
        r.ib = ($urandom_range(0, 9) == 0) ? r.ia : pick_index();
        r.ic = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) == 0) ? r.ia : r.ib)
                                            : pick_index();
        mode = $urandom_range(0, 9);
        if (mode < 6 && hi_s > lo_s) begin
            r.ua = coord_between(lo_s, hi_s);
            r.ub = coord_between(lo_s, hi_s);
            r.uc = coord_between(lo_s, hi_s);
        end else if (mode < 8) begin
            base = ($urandom_range(0, 1) == 0) ? tile_lo : tile_hi;
            r.ua = base;
            r.ub = base;
            r.uc = base + 32'($urandom_range(0, 2)) - 32'd1;
        end else begin
            r.ua = $urandom;
            r.ub = $urandom;
            r.uc = $urandom;
        end
        if (clears_left > 0 && $urandom_range(0, 79) == 0) begin
            r.kind = REQ_CLEAR;
            clears_left--;
        end
        return r;
    endfunction

    task automatic offer(input t_face_req r, input logic typed, input t_bin_result want);
        int          gap;
        t_bin_result predicted;
        gap = (send_idle && $urandom_range(0, 99) < 25) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_req_type <= r.kind;
        i_index_a  <= r.ia;
        i_index_b  <= r.ib;
        i_index_c  <= r.ic;
        i_coord_a  <= r.ua;
        i_coord_b  <= r.ub;
        i_coord_c  <= r.uc;
        do @(posedge i_clk); while (o_in_stall);
        predicted = bin_face(r);
        pending_bins.push_back(typed ? want : predicted);
    endtask

    task automatic write_reg(input logic [tbvc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == tbvc_pkg::CFG_TILE_U_LOW) tile_lo = data;
        else if (idx == tbvc_pkg::CFG_TILE_U_HIGH) tile_hi = data;
    endtask

    task automatic wait_for_results();
        while (pending_bins.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    function automatic void check_result();
        t_bin_result want;
        if (pending_bins.size() == 0) begin
            $error("result item with no request pending");
            errors++;
        end else begin
            want = pending_bins.pop_front();
            compare_field("in_tile", 32'(want.in_tile), 32'(o_in_tile));
            compare_field("new_a", 32'(want.na), 32'(o_new_a));
            compare_field("new_b", 32'(want.nb), 32'(o_new_b));
            compare_field("new_c", 32'(want.nc), 32'(o_new_c));
            compare_field("faces_in_tile", 32'(want.faces), 32'(o_faces_in_tile));
            compare_field("vertices_in_tile", 32'(want.verts), 32'(o_vertices_in_tile));
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) check_result();
        if (hold_arm && !hold_done) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= recv_idle && ($urandom_range(0, 99) < 25);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("triangle_tile_bin_vertex_compact_test failed");
            $finish;
        end
    end

    initial begin
        int          phase;
        logic [31:0] lo_w;
        logic [31:0] hi_w;
        // default tile [0, 0x7FFFFFFF)
        directed_rows = '{
            '{'{REQ_FACE, 16'h0000, 16'h0001, 16'h0002, 32'h0, 32'h0, 32'h0},
              1'b1, '{1'b1, 16'd0, 16'd1, 16'd2, 24'd1, 17'd3}},
            '{'{REQ_FACE, 16'h0002, 16'h0001, 16'h0000, 32'h1, 32'h1, 32'h1},
              1'b1, '{1'b1, 16'd2, 16'd1, 16'd0, 24'd2, 17'd3}},
            '{'{REQ_FACE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF},
              1'b1, '{1'b0, 16'd0, 16'd0, 16'd0, 24'd2, 17'd3}},
            '{'{REQ_FACE, 16'hFFFF, 16'h0007, 16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFE},
              1'b1, '{1'b1, 16'd3, 16'd4, 16'd3, 24'd3, 17'd5}},
            '{'{REQ_FACE, 16'h0003, 16'h0004, 16'h0005, 32'hFFFF_FFFF, 32'h0, 32'h0},
              1'b1, '{1'b0, 16'd0, 16'd0, 16'd0, 24'd3, 17'd5}},
            '{'{REQ_FACE, 16'h0003, 16'h0004, 16'h0005, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000},
              1'b1, '{1'b0, 16'd0, 16'd0, 16'd0, 24'd3, 17'd5}},
            '{'{REQ_FACE, 16'hAAAA, 16'h5555, 16'h0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h8000_0000}, 1'b0, UNTYPED},
            '{'{REQ_FACE, 16'h0001, 16'h0001, 16'h0001, 32'h0000_1000, 32'h0, 32'h0},
              1'b0, UNTYPED},
            '{'{REQ_FACE, 16'h8000, 16'hAAAA, 16'h8000, 32'h0, 32'h0, 32'h0},
              1'b0, UNTYPED},
            '{'{REQ_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF},
              1'b1, '{1'b0, 16'd0, 16'd0, 16'd0, 24'd0, 17'd0}},
            '{'{REQ_FACE, 16'h5555, 16'h5555, 16'hAAAA, 32'h1, 32'h2, 32'h3},
              1'b1, '{1'b1, 16'd0, 16'd0, 16'd1, 24'd1, 17'd2}},
            '{'{REQ_FACE, 16'hFFFF, 16'hFFFE, 16'hFFFD, 32'h0000_1000, 32'h0000_2000,
                32'hFFFF_D000}, 1'b0, UNTYPED},
            '{'{REQ_FACE, 16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'h0000_0002}, 1'b0, UNTYPED}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        foreach (directed_rows[k])
            offer(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].want);
        i_valid <= 1'b0;
        wait_for_results();

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    lo_w = 32'h8000_0000;
                    hi_w = 32'h7FFF_FFFF;
                end
                1: begin
                    lo_w = 32'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000;
                    hi_w = lo_w + 32'($urandom_range(1, 32'h0000_8000));
                end
                2: begin
                    lo_w = $urandom;
                    hi_w = lo_w;
                end
                3: begin
                    hi_w = 32'($urandom_range(0, 32'h7000_0000));
                    lo_w = hi_w + 32'($urandom_range(1, 32'h0100_0000));
                end
                4: begin
                    lo_w = 32'h7FFF_FFFE;
                    hi_w = 32'h7FFF_FFFF;
                end
                5: begin
                    lo_w = 32'h8000_0000;
                    hi_w = 32'h8000_0001;
                end
                QUIET_PHASE: begin
                    lo_w = 32'($urandom_range(0, 32'h1000_0000));
                    hi_w = lo_w + 32'($urandom_range(32'h100, 32'h0100_0000));
                end
                default: begin
                    lo_w = tbvc_pkg::TILE_U_LOW_RESET;
                    hi_w = tbvc_pkg::TILE_U_HIGH_RESET;
                end
            endcase
            write_reg(tbvc_pkg::CFG_TILE_U_LOW, lo_w);
            write_reg(tbvc_pkg::CFG_TILE_U_HIGH, hi_w);
            // unmapped indexes must leave the tile bounds alone
            if (phase == 1) begin
                write_reg(CFG_SPARE_A, $urandom);
                write_reg(CFG_SPARE_B, $urandom);
            end

            foreach (vtx_pool[k]) vtx_pool[k] = 16'($urandom);
            vtx_pool[0] = 16'h0000;
            vtx_pool[1] = 16'hFFFF;

            send_idle = (phase != QUIET_PHASE);
            recv_idle <= (phase != QUIET_PHASE);
            if (phase == QUIET_PHASE) hold_arm <= 1'b1;

            repeat (ITEMS_PER_PHASE) offer(random_request(), 1'b0, UNTYPED);
            i_valid <= 1'b0;
            wait_for_results();
        end

        if (errors == 0) begin
            $display("triangle_tile_bin_vertex_compact_test passed");
        end else begin
            $display("triangle_tile_bin_vertex_compact_test failed");
        end
        $finish;
    end

endmodule
